FILE: hdl/aip_pkg.sv
// Package with shared types and character constants of the decimal integer parser.
package aip_pkg;

   typedef logic [1:0] status_type;
   typedef logic [1:0] skip_type;
   typedef logic [1:0] csr_index_type;

   localparam status_type STATUS_NUMBER  = 2'd0;
   localparam status_type STATUS_TIMEOUT = 2'd1;
   localparam status_type STATUS_REJECT  = 2'd2;

   localparam skip_type SKIP_REJECT      = 2'd0;
   localparam skip_type SKIP_NON_NUMERIC = 2'd1;
   localparam skip_type SKIP_SPACE       = 2'd2;

   localparam csr_index_type CSR_IGNORE_CHAR   = 2'd0;
   localparam csr_index_type CSR_SKIP_MODE     = 2'd1;
   localparam csr_index_type CSR_TIMEOUT_TICKS = 2'd2;

   localparam logic OPCODE_BYTE = 1'b0;
   localparam logic OPCODE_TICK = 1'b1;

   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_LF    = 8'h0A;

   localparam logic [35:0] POSITIVE_LIMIT = 36'h0_7FFF_FFFF;

   localparam logic [7:0]  IGNORE_CHAR_RESET   = 8'd0;
   localparam skip_type    SKIP_MODE_RESET     = SKIP_NON_NUMERIC;
   localparam logic [15:0] TIMEOUT_TICKS_RESET = 16'd500;

   typedef struct packed {
      logic signed [31:0] value;
      status_type         status;
      logic               overflow;
      logic               last;
   } result_type;

   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } push_type;

   function automatic logic is_digit(input logic [7:0] b);
      return (b >= CHAR_ZERO) && (b <= CHAR_NINE);
   endfunction

   function automatic logic is_space(input logic [7:0] b);
      return (b == CHAR_SPACE) || (b == CHAR_TAB) || (b == CHAR_CR) || (b == CHAR_LF);
   endfunction

endpackage

FILE: hdl/aip_parse.sv
// Parser state, configuration registers and per-transaction result generation.
module aip_parse (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  logic                   opcode,
   input  logic [7:0]             rx_byte,
   input  logic                   csr_write_enable,
   input  aip_pkg::csr_index_type csr_index,
   input  logic [15:0]            csr_write_data,
   output aip_pkg::push_type      push
);

   logic [7:0]        ignore_char_ff;
   aip_pkg::skip_type skip_mode_ff;
   logic [15:0]       timeout_ticks_ff;

   logic        in_number_ff, in_number_in;
   logic        negative_ff, negative_in;
   logic [31:0] acc_ff, acc_in;
   logic        overflow_ff, overflow_in;
   logic [15:0] quiet_ff, quiet_in;
   logic        reported_ff, reported_in;

   logic [3:0]          digit_value;
   logic [35:0]         acc_step;
   logic [15:0]         quiet_sat;
   logic                byte_digit;
   logic                reject;
   aip_pkg::result_type number_result;
   aip_pkg::result_type timeout_result;
   aip_pkg::result_type reject_result;
   aip_pkg::push_type   push_comb;

   assign digit_value = 4'(rx_byte - aip_pkg::CHAR_ZERO);
   assign acc_step    = {1'b0, acc_ff, 3'b000} + {3'b000, acc_ff, 1'b0} + {32'd0, digit_value};
   assign quiet_sat   = (quiet_ff == 16'hFFFF) ? quiet_ff : quiet_ff + 16'd1;
   assign byte_digit  = aip_pkg::is_digit(rx_byte);
   assign reject      = (skip_mode_ff == aip_pkg::SKIP_REJECT) ||
                        ((skip_mode_ff == aip_pkg::SKIP_SPACE) && !aip_pkg::is_space(rx_byte));

   always_comb begin
      number_result.value    = negative_ff ? (32'd0 - acc_ff) : acc_ff;
      number_result.status   = aip_pkg::STATUS_NUMBER;
      number_result.overflow = overflow_ff;
      number_result.last     = 1'b0;
      timeout_result         = '0;
      timeout_result.status  = aip_pkg::STATUS_TIMEOUT;
      reject_result          = '0;
      reject_result.status   = aip_pkg::STATUS_REJECT;
   end

   always_comb begin
      in_number_in = in_number_ff;
      negative_in  = negative_ff;
      acc_in       = acc_ff;
      overflow_in  = overflow_ff;
      quiet_in     = quiet_ff;
      reported_in  = reported_ff;
      push_comb    = '0;
      if (opcode == aip_pkg::OPCODE_TICK) begin
         quiet_in = quiet_sat;
         if (quiet_sat >= timeout_ticks_ff) begin
            if (in_number_ff) begin
               push_comb.count = 2'd1;
               push_comb.first = number_result;
               in_number_in    = 1'b0;
               negative_in     = 1'b0;
               acc_in          = 32'd0;
               overflow_in     = 1'b0;
               quiet_in        = 16'd0;
               reported_in     = 1'b0;
            end else if (!reported_ff) begin
               push_comb.count = 2'd1;
               push_comb.first = timeout_result;
               reported_in     = 1'b1;
            end
         end
      end else begin
         quiet_in    = 16'd0;
         reported_in = 1'b0;
         if (in_number_ff && rx_byte == ignore_char_ff) begin
            // The separator character is dropped inside a number.
         end else if (in_number_ff && byte_digit) begin
            acc_in = acc_step[31:0];
            if (acc_step > aip_pkg::POSITIVE_LIMIT) begin
               overflow_in = 1'b1;
            end
         end else begin
            if (in_number_ff) begin
               push_comb.count = 2'd1;
               push_comb.first = number_result;
            end
            if (rx_byte == aip_pkg::CHAR_MINUS || byte_digit) begin
               in_number_in = 1'b1;
               negative_in  = 1'b0;
               acc_in       = 32'd0;
               overflow_in  = 1'b0;
               if (rx_byte != ignore_char_ff) begin
                  if (rx_byte == aip_pkg::CHAR_MINUS) begin
                     negative_in = 1'b1;
                  end else begin
                     acc_in = {28'd0, digit_value};
                  end
               end
            end else begin
               in_number_in = 1'b0;
               negative_in  = 1'b0;
               acc_in       = 32'd0;
               overflow_in  = 1'b0;
               if (reject) begin
                  if (in_number_ff) begin
                     push_comb.count  = 2'd2;
                     push_comb.second = reject_result;
                  end else begin
                     push_comb.count = 2'd1;
                     push_comb.first = reject_result;
                  end
               end
            end
         end
      end
      case (push_comb.count)
         2'd1:    push_comb.first.last = 1'b1;
         2'd2:    push_comb.second.last = 1'b1;
         default: push_comb.first.last = 1'b0;
      endcase
      if (!accept) begin
         push_comb.count = 2'd0;
      end
   end

   assign push = push_comb;

   always_ff @(posedge clock) begin
      if (reset) begin
         ignore_char_ff   <= aip_pkg::IGNORE_CHAR_RESET;
         skip_mode_ff     <= aip_pkg::SKIP_MODE_RESET;
         timeout_ticks_ff <= aip_pkg::TIMEOUT_TICKS_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            aip_pkg::CSR_IGNORE_CHAR:   ignore_char_ff   <= csr_write_data[7:0];
            aip_pkg::CSR_SKIP_MODE:     skip_mode_ff     <= csr_write_data[1:0];
            aip_pkg::CSR_TIMEOUT_TICKS: timeout_ticks_ff <= csr_write_data;
            default:                    ignore_char_ff   <= ignore_char_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_number_ff <= 1'b0;
         negative_ff  <= 1'b0;
         acc_ff       <= 32'd0;
         overflow_ff  <= 1'b0;
         quiet_ff     <= 16'd0;
         reported_ff  <= 1'b0;
      end else if (accept) begin
         in_number_ff <= in_number_in;
         negative_ff  <= negative_in;
         acc_ff       <= acc_in;
         overflow_ff  <= overflow_in;
         quiet_ff     <= quiet_in;
         reported_ff  <= reported_in;
      end
   end

endmodule

FILE: hdl/aip_rspq.sv
// Four-entry result queue that takes up to two results per cycle and returns one per cycle while rsp_stall is low.
module aip_rspq (
   input  logic                clock,
   input  logic                reset,
   input  aip_pkg::push_type   push,
   input  logic                rsp_stall,
   output logic                rsp_valid,
   output aip_pkg::result_type head,
   output logic                room
);

   aip_pkg::result_type entry_ff [4];
   logic [1:0] wr_ptr_ff, wr_ptr_in;
   logic [1:0] rd_ptr_ff, rd_ptr_in;
   logic [2:0] count_ff, count_in;
   logic       pop;

   assign rsp_valid = (count_ff != 3'd0);
   assign head      = entry_ff[rd_ptr_ff];
   assign room      = (count_ff <= 3'd2);
   assign pop       = rsp_valid && !rsp_stall;
   assign wr_ptr_in = wr_ptr_ff + push.count;
   assign rd_ptr_in = rd_ptr_ff + {1'b0, pop};
   assign count_in  = count_ff + {1'b0, push.count} - {2'b00, pop};

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         entry_ff[wr_ptr_ff + 2'd1] <= push.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 2'd0;
         rd_ptr_ff <= 2'd0;
         count_ff  <= 3'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

FILE: hdl/ascii_decimal_integer_parser_unit.sv
// Top level of the streaming decimal integer parser.
// Results are written into the registered result queue and offered on rsp_valid from there.
// Throughput: one transaction per cycle while req_stall is low; the state update and multiply-by-ten add are one pass.
// A transaction may yield two results; req_stall rises while more than two results wait
// in the four-entry result queue.
// Reset is synchronous and active high; it restores registers and empties the queue.
module ascii_decimal_integer_parser_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_opcode,
   input  logic [7:0]         req_rx_byte,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_value,
   output logic [1:0]         rsp_status,
   output logic               rsp_overflow,
   output logic               rsp_last,
   input  logic               csr_write_enable,
   input  logic [1:0]         csr_index,
   input  logic [15:0]        csr_write_data
);

   aip_pkg::push_type   push;
   aip_pkg::result_type head;
   logic                room;
   logic                accept;

   assign req_stall = !room;
   assign accept    = req_valid && room;

   aip_parse u_parse (
      .clock            (clock),
      .reset            (reset),
      .accept           (accept),
      .opcode           (req_opcode),
      .rx_byte          (req_rx_byte),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .push             (push)
   );

   aip_rspq u_rspq (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .head      (head),
      .room      (room)
   );

   assign rsp_value    = head.value;
   assign rsp_status   = head.status;
   assign rsp_overflow = head.overflow;
   assign rsp_last     = head.last;

endmodule

FILE: hdl/aip_checker.sv
// Port-level checker for the decimal integer parser and its bind statement.
module aip_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic signed [31:0] rsp_value,
   input logic [1:0]         rsp_status,
   input logic               rsp_overflow,
   input logic               rsp_last
);

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid && !req_stall)
      else $error("Result channel not empty after reset.");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_value) && $stable(rsp_status)
                                 && $stable(rsp_overflow) && $stable(rsp_last))
      else $error("Stalled result transaction changed.");

   a_no_number_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == aip_pkg::STATUS_TIMEOUT ||
                    rsp_status == aip_pkg::STATUS_REJECT)
      |-> rsp_value == 32'sd0 && !rsp_overflow)
      else $error("Timeout or reject result carries a value.");

   a_timeout_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == aip_pkg::STATUS_TIMEOUT |-> rsp_last)
      else $error("Timeout result is not the final result of its transaction.");

endmodule

bind ascii_decimal_integer_parser_unit aip_checker u_aip_checker (.*);
